FILE: src/bfdh_pkg.sv
// Shared constants and controller/datapath interface types for the bloom filter core.
// No dependencies.
package bfdh_pkg;

  localparam int MAX_BITS = 1024;
  localparam int IDX_W    = $clog2(MAX_BITS);
  localparam int N_W      = IDX_W + 1;
  localparam int SIZE_W   = 11;
  localparam int KEY_W    = 31;
  localparam int CNT_W    = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       save;
    logic [1:0] save_sel;
    logic       mem_en;
    logic       mem_we;
    logic [1:0] mem_sel;
    logic       clr;
    logic       acc;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic req;
    logic clr_last;
    logic out_busy;
  } ctl_stat_t;

endpackage

FILE: src/bloom_filter_digit_hash_core.sv
// Bloom filter core with three digit hashes (key mod n, key/n mod n, key/n/n mod n).
// Takes one beat at a time: the input stalls from acceptance until the result is loaded,
// most of that spent in three 31-step passes of one divider.
// Reset: synchronous; a sweep then zeroes all 1024 store bits, input stalls meanwhile.
// Depends on bfdh_pkg, bfdh_ctrl, bfdh_dpath, bfdh_ram.
module bloom_filter_digit_hash_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bfdh_pkg::SIZE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [bfdh_pkg::KEY_W-1:0]  key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        probably_present
);
  import bfdh_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  bfdh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  bfdh_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .key             (key),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .probably_present(probably_present),
    .cmd             (cmd),
    .stat            (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice without a result");

  a_no_write_during_clear: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr && cmd.mem_we))
    else $error("store write during clear sweep");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_load_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && !in_stall))
    else $error("key loaded without an accepted beat");

endmodule

FILE: src/bfdh_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bfdh_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/bfdh_ctrl.sv
// Sequencer for the bloom filter: clear sweep, three divisions, store access, result.
// Depends on bfdh_pkg.
module bfdh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bfdh_pkg::ctl_stat_t stat,
  output bfdh_pkg::ctl_cmd_t  cmd
);
  import bfdh_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SAVE  = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(KEY_W - 1);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic [1:0]       pass, pass_next;
  logic [1:0]       mem_cnt, mem_cnt_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    pass_next    = pass;
    mem_cnt_next = mem_cnt;
    cmd          = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr    = 1'b1;
        cmd.mem_en = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          pass_next    = '0;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step     = 1'b1;
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == DIV_LAST) begin
          state_next = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd.save     = 1'b1;
        cmd.save_sel = pass;
        div_cnt_next = '0;
        mem_cnt_next = '0;
        if (pass == 2'd2) begin
          state_next = (stat.req == REQ_QUERY) ? ST_RD : ST_WR;
        end else begin
          pass_next  = pass + 2'd1;
          state_next = ST_DIV;
        end
      end
      ST_WR: begin
        cmd.mem_en   = 1'b1;
        cmd.mem_we   = 1'b1;
        cmd.mem_sel  = mem_cnt;
        mem_cnt_next = mem_cnt + 2'd1;
        if (mem_cnt == 2'd2) begin
          state_next = ST_DONE;
        end
      end
      ST_RD: begin
        cmd.mem_en   = (mem_cnt != 2'd3);
        cmd.mem_sel  = mem_cnt;
        cmd.acc      = (mem_cnt != 2'd0);
        mem_cnt_next = mem_cnt + 2'd1;
        if (mem_cnt == 2'd3) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      div_cnt <= '0;
      pass    <= '0;
      mem_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      pass    <= pass_next;
      mem_cnt <= mem_cnt_next;
    end
  end

endmodule

FILE: src/bfdh_dpath.sv
// Datapath: size register, shared restoring divider, index registers, bit store, result.
// Depends on bfdh_pkg and bfdh_ram.
module bfdh_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bfdh_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       req_type,
  input  logic [bfdh_pkg::KEY_W-1:0]  key,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       probably_present,
  input  bfdh_pkg::ctl_cmd_t          cmd,
  output bfdh_pkg::ctl_stat_t         stat
);
  import bfdh_pkg::*;

  logic [SIZE_W-1:0] filter_size;
  logic [31:0]       size_w;
  logic [N_W-1:0]    n_eff;

  logic              req;
  logic [KEY_W-1:0]  dvd;
  logic [N_W-1:0]    rem;
  logic [N_W:0]      trial;
  logic              ge;
  logic [N_W:0]      diff;
  logic [IDX_W-1:0]  idx [3];
  logic              hit;
  logic [IDX_W-1:0]  clr_addr;
  logic [IDX_W-1:0]  addr;
  logic              rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_size <= SIZE_RESET;
    end else if (cfg_write) begin
      filter_size <= cfg_data;
    end
  end

  always_comb begin
    size_w = 32'(filter_size);
    if (size_w == 32'd0) begin
      n_eff = N_W'(1);
    end else if (size_w > 32'(MAX_BITS)) begin
      n_eff = N_W'(MAX_BITS);
    end else begin
      n_eff = N_W'(size_w);
    end
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, dvd[KEY_W-1]};
  assign ge    = (trial >= {1'b0, n_eff});
  assign diff  = trial - {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_type;
      dvd <= key;
      rem <= '0;
      hit <= 1'b1;
    end else begin
      if (cmd.step) begin
        dvd <= {dvd[KEY_W-2:0], ge};
        rem <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
      end
      if (cmd.save) begin
        idx[cmd.save_sel] <= rem[IDX_W-1:0];
        rem <= '0;
      end
      if (cmd.acc) begin
        hit <= hit & rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  assign addr = cmd.clr ? clr_addr : idx[cmd.mem_sel];

  bfdh_ram #(
    .WIDTH(1),
    .DEPTH(MAX_BITS)
  ) u_store (
    .clk  (clk),
    .en   (cmd.mem_en),
    .we   (cmd.mem_we | cmd.clr),
    .addr (addr),
    .wdata(!cmd.clr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      probably_present <= (req == REQ_QUERY) ? hit : 1'b0;
    end
  end

  assign stat.req      = req;
  assign stat.clr_last = (32'(clr_addr) == 32'(MAX_BITS - 1));
  assign stat.out_busy = out_valid & out_stall;

endmodule
